@@ rtl/rrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_pkg: shared types for the retransmit retry table
// Transaction payloads, table entry layout, codes and the cell control group.
// ----------------------------------------------------------------------------
package rrt_pkg;

	localparam int ENTRIES_DEF = 16;

	typedef enum logic [1:0] {
		MD_INSERT = 2'd0,
		MD_TICK   = 2'd1,
		MD_ACK    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		K_RESEND    = 3'd0,
		K_TIMEOUT   = 3'd1,
		K_TICK_DONE = 3'd2,
		K_INSERTED  = 3'd3,
		K_FULL      = 3'd4,
		K_ACK_HIT   = 3'd5,
		K_ACK_MISS  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_ACK
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] command;
		logic [15:0] message_handle;
		logic [7:0]  max_count;
		logic [31:0] period_ms;
		logic        needs_ack;
		logic [47:0] now_ms;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] out_command;
		logic [15:0] out_handle;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [15:0] command;
		logic [15:0] handle;
		logic [7:0]  limit;
		logic [7:0]  sent;
		logic [31:0] period;
		logic [47:0] last_time;
		logic        wants_ack;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;

	typedef struct packed {
		logic   expire;
		logic   resend;
		entry_t next;
	} eval_t;

endpackage
`default_nettype wire

@@ rtl/rrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_cell: one table slot in the shift chain
// Takes its younger neighbor on a shift; a direct write wins over the shift.
// ----------------------------------------------------------------------------
module rrt_cell (
	input  wire               clk,
	input  rrt_pkg::cell_ctl_t ctl,
	input  rrt_pkg::entry_t   nbr,
	input  rrt_pkg::entry_t   wr_data,
	output rrt_pkg::entry_t   q
);
	import rrt_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			entry_q <= wr_data;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

@@ rtl/rrt_head_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_head_eval: retry decision for the entry at the head of the chain
// Expired when sent reaches limit; resend when now is past last + period.
// ----------------------------------------------------------------------------
module rrt_head_eval (
	input  rrt_pkg::entry_t head,
	input  wire [47:0]      now,
	output rrt_pkg::eval_t  ev
);
	import rrt_pkg::*;

	logic [48:0] due;

	always_comb begin
		due       = {1'b0, head.last_time} + {17'b0, head.period};
		ev.expire = (head.sent >= head.limit);
		ev.resend = !ev.expire && ({1'b0, now} > due);
		ev.next   = head;
		if (ev.resend) begin
			ev.next.sent      = head.sent + 8'd1;
			ev.next.last_time = now;
		end
	end

endmodule
`default_nettype wire

@@ rtl/retransmit_retry_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_retry_table: pending message table with resend and timeout
// Insertion-ordered table of messages waiting for resend or acknowledge.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel (in_valid/in_ready/in_data): one transaction per request,
//       mode insert, tick scan or acknowledge.
//   out channel (out_valid/out_ready/out_data): result transactions; the
//       final one of a request carries last = 1.
// Per mode:
//   insert: result in the cycle after acceptance; the next request is
//           accepted as soon as the output is free.
//   tick:   each used entry passes the head of the cell chain once, then
//           the done result. ack: the whole chain rotates once, keeping order.
//   Scans pass the chain's one head at one entry a cycle unless stalled.
// Reset: table empties (fill count cleared), controller idle, no output.
// Stall: while out_ready is low and a result is held, the chain freezes and
//   no request is accepted; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module retransmit_retry_table #(
	parameter int ENTRIES = rrt_pkg::ENTRIES_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  rrt_pkg::in_t  in_data,
	output logic          out_valid,
	input  wire           out_ready,
	output rrt_pkg::out_t out_data
);
	import rrt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	// control state
	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;      // used entries, always a prefix of the chain
	logic [CW-1:0] steps_q, steps_d;  // entries left to visit in a scan
	logic          hit_q, hit_d;      // ack already matched during this scan
	logic          out_valid_q;
	out_t          out_q;

	// payload latched at request acceptance
	logic [47:0]   now_q;
	logic [15:0]   cmd_q;

	// chain
	entry_t        cell_q [ENTRIES];
	cell_ctl_t     ctl [ENTRIES];
	logic          shift, wr_en;
	logic [CW-1:0] wr_pos;
	entry_t        wr_data, new_entry;
	eval_t         ev;

	// result path
	logic          emit, o_free;
	out_t          o;

	assign o_free = !out_valid_q || out_ready;

	always_comb begin
		new_entry.command   = in_data.command;
		new_entry.handle    = in_data.message_handle;
		new_entry.limit     = in_data.max_count;
		new_entry.sent      = 8'd0;
		new_entry.period    = in_data.period_ms;
		new_entry.last_time = in_data.now_ms;
		new_entry.wants_ack = in_data.needs_ack;
	end

	rrt_head_eval u_eval (
		.head (cell_q[0]),
		.now  (now_q),
		.ev   (ev)
	);

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			entry_t nbr;
			if (gi < ENTRIES - 1) begin : g_mid
				assign nbr = cell_q[gi + 1];
			end else begin : g_tail
				assign nbr = cell_q[gi];
			end
			assign ctl[gi].shift = shift;
			assign ctl[gi].wr    = wr_en && (wr_pos == CW'(gi));
			rrt_cell u_cell (
				.clk     (clk),
				.ctl     (ctl[gi]),
				.nbr     (nbr),
				.wr_data (wr_data),
				.q       (cell_q[gi])
			);
		end
	endgenerate

	// next state, chain control and result selection
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		steps_d  = steps_q;
		hit_d    = hit_q;
		in_ready = 1'b0;
		emit     = 1'b0;
		o        = '0;
		shift    = 1'b0;
		wr_en    = 1'b0;
		wr_pos   = cnt_q;
		wr_data  = ev.next;
		case (state_q)
			ST_IDLE: begin
				in_ready = o_free;
				if (in_valid && o_free) begin
					case (mode_t'(in_data.mode))
						MD_INSERT: begin
							emit          = 1'b1;
							o.out_command = in_data.command;
							o.out_handle  = in_data.message_handle;
							o.last        = 1'b1;
							if (cnt_q == CW'(ENTRIES)) begin
								o.kind = K_FULL;
							end else begin
								o.kind  = K_INSERTED;
								wr_en   = 1'b1;
								wr_data = new_entry;
								cnt_d   = cnt_q + 1'b1;
							end
						end
						MD_TICK: begin
							steps_d = cnt_q;
							state_d = ST_TICK;
						end
						MD_ACK: begin
							steps_d = cnt_q;
							hit_d   = 1'b0;
							state_d = ST_ACK;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TICK: begin
				if (o_free) begin
					if (steps_q == '0) begin
						emit    = 1'b1;
						o.kind  = K_TICK_DONE;
						o.last  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						// pop the head; keep it at the tail unless expired
						shift         = 1'b1;
						steps_d       = steps_q - 1'b1;
						o.out_command = cell_q[0].command;
						o.out_handle  = cell_q[0].handle;
						if (ev.expire) begin
							cnt_d  = cnt_q - 1'b1;
							emit   = cell_q[0].wants_ack;
							o.kind = K_TIMEOUT;
						end else begin
							wr_en  = 1'b1;
							wr_pos = cnt_q - 1'b1;
							emit   = ev.resend;
							o.kind = K_RESEND;
						end
					end
				end
			end
			ST_ACK: begin
				if (o_free) begin
					if (steps_q == '0) begin
						emit          = !hit_q;
						o.kind        = K_ACK_MISS;
						o.out_command = cmd_q;
						o.last        = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						shift   = 1'b1;
						steps_d = steps_q - 1'b1;
						wr_data = cell_q[0];
						if (!hit_q && (cell_q[0].command == cmd_q)) begin
							hit_d         = 1'b1;
							cnt_d         = cnt_q - 1'b1;
							emit          = 1'b1;
							o.kind        = K_ACK_HIT;
							o.out_command = cell_q[0].command;
							o.out_handle  = cell_q[0].handle;
							o.last        = 1'b1;
						end else begin
							wr_en  = 1'b1;
							wr_pos = cnt_q - 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			steps_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			steps_q <= steps_d;
			hit_q   <= hit_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= o;
		end
		if (in_valid && in_ready) begin
			now_q <= in_data.now_ms;
			cmd_q <= in_data.command;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the retransmit retry table
// Queued requests drive the input channel with random gaps. A behavioral
// table model predicts every result transaction. A monitor compares each
// accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
	import rrt_pkg::*;

	localparam int DEPTH     = ENTRIES_DEF;
	localparam int MAX_CYC   = 2000000;

	// mode value with no operation; the block ignores it
	localparam logic [1:0] MD_RSVD = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	retransmit_retry_table #(.ENTRIES(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Table model: valid entries always form a prefix, oldest at index 0.
	entry_t tbl_entry [DEPTH];
	int     tbl_used = 0;

	out_t   pending_results[$];
	in_t    request_queue[$];
	int     errors = 0;
	int     cycles = 0;
	bit     quiet_phase = 1'b0;   // no idling on either side while set
	bit     hold_sender = 1'b0;   // sender pauses while set

	// Append one predicted result transaction.
	task automatic queue_result(out_t r);
		pending_results = {pending_results, r};
	endtask

	// Append one request transaction to the driver's queue.
	task automatic queue_request(in_t r);
		request_queue = {request_queue, r};
	endtask

	function automatic out_t mk_result(kind_t k, logic [15:0] c, logic [15:0] h,
		logic l);
		out_t r;
		r.kind = k;
		r.out_command = c;
		r.out_handle = h;
		r.last = l;
		return r;
	endfunction

	task automatic drop_entry(int idx);
		for (int j = idx; j < DEPTH - 1; j++)
			tbl_entry[j] = tbl_entry[j + 1];
		tbl_used--;
	endtask

	// Predict the result transactions of one accepted request.
	task automatic predict_table(in_t rq);
		int i;
		bit hit;
		logic [48:0] due;
		i = 0;
		hit = 1'b0;
		case (rq.mode)
			MD_INSERT: begin
				if (tbl_used >= DEPTH) begin
					queue_result(mk_result(K_FULL, rq.command,
						rq.message_handle, 1'b1));
				end else begin
					tbl_entry[tbl_used].command   = rq.command;
					tbl_entry[tbl_used].handle    = rq.message_handle;
					tbl_entry[tbl_used].limit     = rq.max_count;
					tbl_entry[tbl_used].sent      = 8'd0;
					tbl_entry[tbl_used].period    = rq.period_ms;
					tbl_entry[tbl_used].last_time = rq.now_ms;
					tbl_entry[tbl_used].wants_ack = rq.needs_ack;
					tbl_used++;
					queue_result(mk_result(K_INSERTED, rq.command,
						rq.message_handle, 1'b1));
				end
			end
			MD_TICK: begin
				while (i < tbl_used) begin
					if (tbl_entry[i].sent >= tbl_entry[i].limit) begin
						// expired: timeout only for request-ack messages
						if (tbl_entry[i].wants_ack)
							queue_result(mk_result(K_TIMEOUT,
								tbl_entry[i].command, tbl_entry[i].handle, 1'b0));
						drop_entry(i);
					end else begin
						// 49-bit sum: no wrap in the due time
						due = {1'b0, tbl_entry[i].last_time} + tbl_entry[i].period;
						if ({1'b0, rq.now_ms} > due) begin
							tbl_entry[i].sent++;
							tbl_entry[i].last_time = rq.now_ms;
							queue_result(mk_result(K_RESEND,
								tbl_entry[i].command, tbl_entry[i].handle, 1'b0));
						end
						i++;
					end
				end
				queue_result(mk_result(K_TICK_DONE, 16'd0, 16'd0, 1'b1));
			end
			MD_ACK: begin
				for (i = 0; i < tbl_used && !hit; i++) begin
					if (tbl_entry[i].command == rq.command) begin
						queue_result(mk_result(K_ACK_HIT,
							tbl_entry[i].command, tbl_entry[i].handle, 1'b1));
						drop_entry(i);
						hit = 1'b1;
					end
				end
				if (!hit)
					queue_result(mk_result(K_ACK_MISS, rq.command,
						16'd0, 1'b1));
			end
			default: ;  // unused mode: ignored
		endcase
	endtask

	task automatic report_mismatch(string what, out_t got, out_t want);
		$display({"mismatch %s: got kind %0d cmd %h hnd %h last %0d,",
			" want kind %0d cmd %h hnd %h last %0d"},
			what, got.kind, got.out_command, got.out_handle, got.last,
			want.kind, want.out_command, want.out_handle, want.last);
		errors++;
	endtask

	// Driver: presents queued requests, random gaps outside the quiet phase.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_table(in_data);
				if (!hold_sender && request_queue.size() > 0
					&& (quiet_phase || $urandom_range(99) >= 20)) begin
					in_data <= request_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid && !hold_sender && request_queue.size() > 0
				&& (quiet_phase || $urandom_range(99) >= 20)) begin
				in_valid <= 1'b1;
				in_data  <= request_queue.pop_front();
			end
		end
	end

	// Monitor: checks each result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected", out_data, '0);
				end else if (out_data !== pending_results[0]) begin
					report_mismatch("field", out_data, pending_results[0]);
					void'(pending_results.pop_front());
				end else begin
					void'(pending_results.pop_front());
				end
			end
			out_ready <= quiet_phase || ($urandom_range(99) >= 20);
		end
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic in_t mk_req(mode_t md, logic [15:0] c, logic [15:0] h,
		logic [7:0] lim, logic [31:0] per, logic ack, logic [47:0] now);
		in_t r;
		r.mode = md;
		r.command = c;
		r.message_handle = h;
		r.max_count = lim;
		r.period_ms = per;
		r.needs_ack = ack;
		r.now_ms = now;
		return r;
	endfunction

	// Stimulus with a running clock in ms so ticks see growing time.
	logic [47:0] now_clk;

	task automatic add_random(int count);
		in_t r;
		int sel;
		logic [15:0] c;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			now_clk = now_clk + $urandom_range(40);
			if (sel < 40) begin
				c = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
				r = mk_req(MD_INSERT, c, 16'($urandom), 8'($urandom_range(4)),
					32'($urandom_range(60)), 1'($urandom), now_clk);
				if ($urandom_range(19) == 0) begin
					r.max_count = 8'($urandom);
					r.period_ms = $urandom;
				end
			end else if (sel < 75) begin
				r = mk_req(MD_TICK, 16'($urandom), 16'($urandom), 8'($urandom),
					$urandom, 1'($urandom), now_clk);
			end else if (sel < 97) begin
				r = mk_req(MD_ACK, 16'($urandom_range(15)), 16'($urandom),
					8'($urandom), $urandom, 1'($urandom), now_clk);
				if ($urandom_range(4) == 0) r.command = 16'($urandom);
			end else begin
				r = mk_req(MD_INSERT, 16'($urandom), 16'($urandom), 8'($urandom),
					$urandom, 1'($urandom), now_clk);
				r.mode = MD_RSVD;  // unused mode, ignored by the block
			end
			queue_request(r);
		end
	endtask

	task automatic wait_drained();
		while (request_queue.size() > 0 || in_valid || pending_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		now_clk = 48'd1000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, zero limit, full table, acks, unused mode.
		queue_request(mk_req(MD_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF,
			32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFE));
		queue_request(mk_req(MD_INSERT, 16'h0000, 16'h0000, 8'h00,
			32'h0, 1'b0, 48'h0));
		queue_request(mk_req(MD_INSERT, 16'h0001, 16'h1234, 8'h00,
			32'h0, 1'b1, 48'h0));
		queue_request(mk_req(MD_INSERT, 16'h0002, 16'h5678, 8'h01,
			32'h0, 1'b1, 48'h0));
		queue_request(mk_req(MD_TICK, 16'h0, 16'h0, 8'h0, 32'h0, 1'b0,
			48'hFFFF_FFFF_FFFF));
		queue_request(mk_req(MD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF,
			32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF));
		queue_request(mk_req(MD_ACK, 16'hFFFF, 16'h0, 8'h0, 32'h0, 1'b0,
			48'h0));
		queue_request(mk_req(MD_ACK, 16'hBEEF, 16'h0, 8'h0, 32'h0, 1'b0,
			48'h0));
		queue_request(mk_req(MD_INSERT, 16'hAAAA, 16'hAAAA, 8'h0, 32'h0,
			1'b0, 48'h0));
		request_queue[$].mode = MD_RSVD;
		for (int n = 0; n < 17; n++)
			queue_request(mk_req(MD_INSERT, 16'(n), 16'(n + 100), 8'd2,
				32'd5, 1'(n), 48'd10));
		queue_request(mk_req(MD_TICK, 16'h0, 16'h0, 8'h0, 32'h0, 1'b0,
			48'd100));
		quiet_phase = 1'b1;
		wait_drained();
		quiet_phase = 1'b0;

		// Sender holds off until everything has arrived, then resumes.
		add_random(120);
		while (request_queue.size() > 60) @(posedge clk);
		hold_sender = 1'b1;
		while (in_valid || pending_results.size() > 0) @(posedge clk);
		hold_sender = 1'b0;
		wait_drained();

		// Long stretch without idling, then more random traffic.
		quiet_phase = 1'b1;
		add_random(80);
		wait_drained();
		quiet_phase = 1'b0;
		add_random(160);
		wait_drained();

		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rrt_pkg.sv
rtl/rrt_cell.sv
rtl/rrt_head_eval.sv
rtl/retransmit_retry_table.sv
tb/tb.sv
